// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each use samples on the rising edge
// of clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever a holds, b holds too.
`define ASSERT_IMPLIES(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever a holds, b holds in the next cycle.
`define ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/bqtr_pkg.sv
// ----------------------------------------------------------------------------
// bqtr_pkg
// Shared types and constants of the quarter-turn bitmap rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bqtr_pkg;

	// Field widths fixed by the interface.
	localparam int GRID_W  = 7;
	localparam int TURN_W  = 2;
	localparam int COORD_W = 6;
	localparam int COUNT_W = 13;
	localparam int CIDX_W  = 2;

	// Dimension limits and reset values.
	localparam int MAX_DIM_DEF   = 64;
	localparam int MAX_DIM_LIMIT = 256;
	localparam int GRID_RESET    = 64;

	// Source coordinates travel at the width of the largest supported grid.
	localparam int CMW = $clog2(MAX_DIM_LIMIT);

	// Depth of the queue between front and back.
	localparam int QDEPTH = 2;

	typedef enum logic [TURN_W-1:0] {
		TURN_NONE = 2'd0,
		TURN_CW   = 2'd1,
		TURN_HALF = 2'd2,
		TURN_CCW  = 2'd3
	} turn_t;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_READ  = 1'b1
	} action_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_GRID_WIDTH    = 2'd0,
		REG_GRID_HEIGHT   = 2'd1,
		REG_QUARTER_TURNS = 2'd2
	} cfg_reg_t;

	// Configuration as seen by the front.
	typedef struct packed {
		logic [GRID_W-1:0] grid_width;
		logic [GRID_W-1:0] grid_height;
		turn_t             quarter_turns;
	} grid_cfg_t;

	// One classified item, held in the queue.
	typedef struct packed {
		action_t        action;
		logic           err;
		logic           cell_in;
		logic [CMW-1:0] src_col;
		logic [CMW-1:0] src_row;
	} q_entry_t;

	// Status reported by the back.
	typedef struct packed {
		logic               s1_valid;
		logic [COUNT_W-1:0] count;
	} bk_status_t;

endpackage

`default_nettype wire

// File: rtl/bqtr_front.sv
// ----------------------------------------------------------------------------
// bqtr_front
// Checks an item's coordinate against the grid and maps a view coordinate
// onto the source bitmap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqtr_front #(
	parameter int MAX_DIM = bqtr_pkg::MAX_DIM_DEF
) (
	input  wire bqtr_pkg::grid_cfg_t        cfg,
	input  wire                             action,
	input  wire [bqtr_pkg::COORD_W-1:0]     col,
	input  wire [bqtr_pkg::COORD_W-1:0]     row,
	input  wire                             cell_in,
	output bqtr_pkg::q_entry_t              entry
);
	import bqtr_pkg::*;

	localparam int DIM_BITS = $clog2(MAX_DIM + 1);
	localparam int DW = (GRID_W > DIM_BITS) ? GRID_W : DIM_BITS;

	logic [DW-1:0] w_eff;
	logic [DW-1:0] h_eff;
	logic [DW-1:0] lim_c;
	logic [DW-1:0] lim_r;
	logic [DW-1:0] c_x;
	logic [DW-1:0] r_x;
	logic [DW-1:0] sx;
	logic [DW-1:0] sy;
	logic          is_read;

	// Effective dimensions, limits of the addressed grid and the view mapping.
	always_comb begin
		w_eff = (DW'(cfg.grid_width) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg.grid_width);
		h_eff = (DW'(cfg.grid_height) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg.grid_height);
		c_x = DW'(col);
		r_x = DW'(row);
		is_read = (action == ACT_READ);

		if (is_read && cfg.quarter_turns[0]) begin
			lim_c = h_eff;
			lim_r = w_eff;
		end else begin
			lim_c = w_eff;
			lim_r = h_eff;
		end

		sx = c_x;
		sy = r_x;
		if (is_read) begin
			case (cfg.quarter_turns)
				TURN_CW: begin
					sx = r_x;
					sy = h_eff - DW'(1) - c_x;
				end
				TURN_HALF: begin
					sx = w_eff - DW'(1) - c_x;
					sy = h_eff - DW'(1) - r_x;
				end
				TURN_CCW: begin
					sx = w_eff - DW'(1) - r_x;
					sy = c_x;
				end
				default: begin
					sx = c_x;
					sy = r_x;
				end
			endcase
		end

		entry.action  = action_t'(action);
		entry.err     = (c_x >= lim_c) || (r_x >= lim_r);
		entry.cell_in = cell_in;
		entry.src_col = CMW'(sx);
		entry.src_row = CMW'(sy);
	end

endmodule

`default_nettype wire

// File: rtl/bqtr_queue.sv
// ----------------------------------------------------------------------------
// bqtr_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqtr_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire bqtr_pkg::q_entry_t push_entry,
	output logic                  full,
	output logic                  head_valid,
	output bqtr_pkg::q_entry_t    head_entry,
	input  wire                   pop
);
	import bqtr_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	q_entry_t        slot_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign full       = (count_q == CW'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: rtl/bqtr_back.sv
// ----------------------------------------------------------------------------
// bqtr_back
// Carries out queued items on the row-wide bitmap memory, keeps the live
// count and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqtr_back #(
	parameter int MAX_DIM = bqtr_pkg::MAX_DIM_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           clear,
	input  wire                           q_valid,
	input  wire bqtr_pkg::q_entry_t       q_entry,
	output logic                          q_pop,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          cell_out,
	output logic                          range_error,
	output logic [bqtr_pkg::COUNT_W-1:0]  live_count,
	output bqtr_pkg::bk_status_t          status
);
	import bqtr_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIM);

	// Bitmap, one row per word; rows not yet written since a clear read as dead.
	logic [MAX_DIM-1:0] mem [MAX_DIM];
	logic [MAX_DIM-1:0] row_valid_q;

	// Stage 1: item under way and its row data.
	logic               s1_valid_q;
	q_entry_t           ent_s1;
	logic [MAX_DIM-1:0] rd_s1;
	logic               rowv_s1;
	logic               byp_s1;
	logic [MAX_DIM-1:0] byp_data_s1;

	logic [COUNT_W-1:0] count_q;

	// Result register.
	logic               out_valid_q;
	logic               cell_q;
	logic               err_q;
	logic [COUNT_W-1:0] live_q;

	logic               out_free;
	logic               s1_adv;
	logic [IDX_W-1:0]   s1_row;
	logic [IDX_W-1:0]   s1_col;
	logic [IDX_W-1:0]   q_row;
	logic [MAX_DIM-1:0] row_eff;
	logic [MAX_DIM-1:0] wr_data;
	logic               wr_en;
	logic               old_bit;
	logic [COUNT_W-1:0] count_next;
	logic               cell_next;

	// Handshake between queue, stage 1 and result register.
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		s1_adv   = s1_valid_q && out_free;
		q_pop    = q_valid && (!s1_valid_q || s1_adv);
		s1_row   = ent_s1.src_row[IDX_W-1:0];
		s1_col   = ent_s1.src_col[IDX_W-1:0];
		q_row    = q_entry.src_row[IDX_W-1:0];
	end

	// Modify the row, update the count and form the result.
	always_comb begin
		if (byp_s1) begin
			row_eff = byp_data_s1;
		end else if (rowv_s1) begin
			row_eff = rd_s1;
		end else begin
			row_eff = '0;
		end
		old_bit = row_eff[s1_col];
		wr_data = row_eff;
		wr_data[s1_col] = ent_s1.cell_in;
		wr_en = s1_adv && (ent_s1.action == ACT_WRITE) && !ent_s1.err;

		count_next = count_q;
		if (wr_en && (old_bit != ent_s1.cell_in)) begin
			count_next = ent_s1.cell_in ? count_q + COUNT_W'(1) : count_q - COUNT_W'(1);
		end
		cell_next = (ent_s1.action == ACT_READ) && !ent_s1.err && old_bit;
	end

	// Memory write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[s1_row] <= wr_data;
		end
	end

	// Memory read port, loaded as an item enters stage 1.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_s1 <= mem[q_row];
		end
	end

	// Stage 1 payload, with a bypass for a write to the same row at that edge.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_s1      <= q_entry;
			byp_s1      <= wr_en && (s1_row == q_row);
			byp_data_s1 <= wr_data;
			rowv_s1     <= row_valid_q[q_row];
		end
	end

	// Control state: stage valid, row valid bits and live count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			row_valid_q <= '0;
			count_q     <= '0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (clear) begin
				row_valid_q <= '0;
				count_q     <= '0;
			end else begin
				if (wr_en) begin
					row_valid_q[s1_row] <= 1'b1;
				end
				count_q <= count_next;
			end
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_adv;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cell_q <= cell_next;
			err_q  <= ent_s1.err;
			live_q <= count_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign cell_out        = cell_q;
	assign range_error     = err_q;
	assign live_count      = live_q;
	assign status.s1_valid = s1_valid_q;
	assign status.count    = count_q;

endmodule

`default_nettype wire

// File: rtl/bitmap_quarter_turn_rotator.sv
// Path: an accepted item passes the queue, stage 1 and the result register before its result is offered.
// Throughput: one item per cycle while out_stall is low, set by the single read
// and single write port of the row memory, with a same-row bypass between adjacent items.
// Reset: all cells dead and count zero at once through per-row valid bits;
// a width or height write clears them the same way, with no clearing pass.
// ----------------------------------------------------------------------------
// bitmap_quarter_turn_rotator
// One-bit bitmap with live count and a rotated read view, built as a
// classifying front, a two-entry queue and a memory back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bitmap_quarter_turn_rotator #(
	parameter int MAX_DIM = bqtr_pkg::MAX_DIM_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire                           action,
	input  wire [bqtr_pkg::COORD_W-1:0]   col,
	input  wire [bqtr_pkg::COORD_W-1:0]   row,
	input  wire                           cell_in,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          cell_out,
	output logic                          range_error,
	output logic [bqtr_pkg::COUNT_W-1:0]  live_count,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [bqtr_pkg::CIDX_W-1:0]    cfg_index,
	input  wire [bqtr_pkg::GRID_W-1:0]    cfg_data
);
	import bqtr_pkg::*;

	grid_cfg_t  cfg_q;
	logic       cfg_wr;
	logic       dim_write;
	logic       push;
	q_entry_t   front_entry;
	logic       q_full;
	logic       q_valid;
	q_entry_t   q_head;
	logic       q_pop;
	bk_status_t bk_status;

	// Configuration registers; a dimension write also clears the bitmap.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign dim_write = cfg_wr && ((cfg_index == REG_GRID_WIDTH) ||
		(cfg_index == REG_GRID_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width    <= GRID_W'(GRID_RESET);
			cfg_q.grid_height   <= GRID_W'(GRID_RESET);
			cfg_q.quarter_turns <= TURN_NONE;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_GRID_WIDTH: begin
					cfg_q.grid_width <= cfg_data;
				end
				REG_GRID_HEIGHT: begin
					cfg_q.grid_height <= cfg_data;
				end
				REG_QUARTER_TURNS: begin
					cfg_q.quarter_turns <= turn_t'(cfg_data[TURN_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Front: classify and map each accepted item.
	bqtr_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.cfg     (cfg_q),
		.action  (action),
		.col     (col),
		.row     (row),
		.cell_in (cell_in),
		.entry   (front_entry)
	);

	assign in_stall = q_full;
	assign push     = in_valid && !in_stall;

	// Queue between front and back.
	bqtr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.full       (q_full),
		.head_valid (q_valid),
		.head_entry (q_head),
		.pop        (q_pop)
	);

	// Back: memory access, count and result register.
	bqtr_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (dim_write),
		.q_valid     (q_valid),
		.q_entry     (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_out    (cell_out),
		.range_error (range_error),
		.live_count  (live_count),
		.status      (bk_status)
	);

	// An out-of-range item never reports a live cell.
	`ASSERT_IMPLIES(a_err_no_cell, out_valid && range_error, !cell_out)
	// A dimension write leaves the live count at zero.
	`ASSERT_NEXT(a_dim_clears_count, dim_write, bk_status.count == '0)
	// The live count moves by at most one cell per cycle outside a clear.
	`ASSERT_NEXT(a_count_step, !dim_write, (bk_status.count == $past(bk_status.count)) || (bk_status.count == $past(bk_status.count) + COUNT_W'(1)) || (bk_status.count == $past(bk_status.count) - COUNT_W'(1)))

endmodule

`default_nettype wire
